### hdl/tss_pkg.sv
package tss_pkg;

    // Field widths of the point and result words.
    localparam int unsigned COORD_W  = 24;
    localparam int unsigned SPEED_W  = 25;
    localparam int unsigned PATH_W   = 33;
    localparam int unsigned COUNT_W  = 8;
    localparam int unsigned IVL_W    = 16;

    // Internal arithmetic widths.
    localparam int unsigned PROD_W   = 48;
    localparam int unsigned SQ_W     = 49;
    localparam int unsigned DIST_W   = 25;
    localparam int unsigned DVS_W    = 24;

    // Square root takes one result bit per step.
    localparam int unsigned ROOT_STEPS = 25;
    localparam int unsigned ROOT_CNT_W = 5;

    // Divider step counts: speed needs 25 quotient bits, the mean all 33.
    localparam int unsigned DIV_CNT_W = 6;
    localparam logic [DIV_CNT_W-1:0] SPEED_DIV_STEPS = 6'd25;
    localparam logic [DIV_CNT_W-1:0] MEAN_DIV_STEPS  = 6'd33;

    typedef logic [IVL_W-1:0] ivl_word_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic                      last_point;
    } point_word_t;

    typedef struct packed {
        logic [SPEED_W-1:0] min_speed;
        logic [SPEED_W-1:0] max_speed;
        logic [SPEED_W-1:0] mean_speed;
        logic [PATH_W-1:0]  path_length;
        logic [COUNT_W-1:0] segment_count;
        logic               track_empty;
    } result_word_t;

    // Status of an iterative arithmetic unit.
    typedef struct packed {
        logic busy;
        logic done;
    } unit_sts_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ_X,
        ST_SQ_Y,
        ST_SQRT_GO,
        ST_SQRT_WAIT,
        ST_SPD_GO,
        ST_SPD_WAIT,
        ST_UPDATE,
        ST_CHECK,
        ST_MEAN_MUL,
        ST_MEAN_GO,
        ST_MEAN_WAIT,
        ST_FINISH
    } seq_state_t;

endpackage

### hdl/tss_chan_if.sv
interface tss_chan_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

### hdl/trajectory_speed_statistics_top.sv
// Speed statistics over a track of points. A point word is taken only while
// the block is idle. The first point of a track, or a point past the segment
// limit, goes through the check state only. A point that forms a segment takes
// two passes through the shared 24x24 multiplier for the squared distance,
// 25 steps of the bit-serial square root and 25 steps of the shared restoring
// divider for the speed. A point marked last on a track with segments adds
// one more multiplier pass for interval times count and a 33-step division
// for the mean before the result word is placed in the output register. The
// output register lets the block take the next point while a result still
// waits; a second result waits in the finish state until the first word is
// taken. An interval of zero is used as one. At most min(MAX_POINTS - 1, 255)
// segments are counted per track; further points are dropped.
module trajectory_speed_statistics_top
    import tss_pkg::*;
#(
    parameter int MAX_POINTS = 256
)
(
    input  logic       clk,
    input  logic       rst_n,
    tss_chan_if.sink   point,
    tss_chan_if.sink   cfg,
    tss_chan_if.source result
);

    localparam int SEG_LIMIT_INT = (MAX_POINTS - 1 > 255) ? 255 : MAX_POINTS - 1;
    localparam logic [COUNT_W-1:0] SEG_LIMIT = COUNT_W'(SEG_LIMIT_INT);

    seq_state_t state_reg;
    seq_state_t state_next;

    point_word_t pt;
    logic        accept;

    logic [IVL_W-1:0] interval_reg;
    logic [IVL_W-1:0] ivl_reg;

    logic signed [COORD_W-1:0] x_reg;
    logic signed [COORD_W-1:0] y_reg;
    logic                      last_reg;
    logic [COORD_W-1:0]        ax_reg;
    logic [COORD_W-1:0]        ay_reg;

    logic signed [COORD_W-1:0] prev_x_reg;
    logic signed [COORD_W-1:0] prev_y_reg;
    logic                      have_prev_reg;
    logic [COUNT_W-1:0]        segs_reg;
    logic [SPEED_W-1:0]        min_reg;
    logic [SPEED_W-1:0]        max_reg;
    logic [PATH_W-1:0]         sum_reg;

    logic [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0] sq_reg;
    logic [COORD_W-1:0] mul_a;
    logic [COORD_W-1:0] mul_b;
    logic [PROD_W-1:0]  prod_next;

    logic               out_valid_reg;
    result_word_t       out_word_reg;
    logic               out_free;
    result_word_t       out_word_next;

    logic signed [COORD_W:0] dx;
    logic signed [COORD_W:0] dy;
    logic [COORD_W:0]        adx;
    logic [COORD_W:0]        ady;

    logic               sqrt_start;
    logic [SQ_W-1:0]    radicand;
    unit_sts_t          sqrt_sts;
    logic [DIST_W-1:0]  seg_dist;

    logic                 div_start;
    logic [PATH_W-1:0]    div_dividend;
    logic [DVS_W-1:0]     div_divisor;
    logic [DIV_CNT_W-1:0] div_steps;
    unit_sts_t            div_sts;
    logic [PATH_W-1:0]    quot;

    logic [SPEED_W-1:0] speed;
    logic [PATH_W:0]    sum_wide;
    logic [PATH_W-1:0]  sum_next;

    assign pt     = point.payload;
    assign accept = point.valid && point.ready;

    // Configuration word: the interval register can always be written.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg <= IVL_W'(1);
        end
        else if (cfg.valid && cfg.ready)
        begin
            interval_reg <= IVL_W'(cfg.payload);
        end
    end

    // Absolute coordinate differences against the previous point.
    always_comb
    begin
        dx  = {pt.pos_x[COORD_W-1], pt.pos_x} - {prev_x_reg[COORD_W-1], prev_x_reg};
        dy  = {pt.pos_y[COORD_W-1], pt.pos_y} - {prev_y_reg[COORD_W-1], prev_y_reg};
        adx = dx[COORD_W] ? -dx : dx;
        ady = dy[COORD_W] ? -dy : dy;
    end

    // Sequencer: next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (have_prev_reg && (segs_reg < SEG_LIMIT))
                    begin
                        state_next = ST_SQ_X;
                    end
                    else
                    begin
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_SQ_X:      state_next = ST_SQ_Y;
            ST_SQ_Y:      state_next = ST_SQRT_GO;
            ST_SQRT_GO:   state_next = ST_SQRT_WAIT;
            ST_SQRT_WAIT:
            begin
                if (sqrt_sts.done)
                begin
                    state_next = ST_SPD_GO;
                end
            end
            ST_SPD_GO:    state_next = ST_SPD_WAIT;
            ST_SPD_WAIT:
            begin
                if (div_sts.done)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:    state_next = ST_CHECK;
            ST_CHECK:
            begin
                if (!last_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (segs_reg == '0)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_MEAN_MUL;
                end
            end
            ST_MEAN_MUL:  state_next = ST_MEAN_GO;
            ST_MEAN_GO:   state_next = ST_MEAN_WAIT;
            ST_MEAN_WAIT:
            begin
                if (div_sts.done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // Sequencer: unit controls and operand selection.
    always_comb
    begin
        point.ready  = 1'b0;
        mul_a        = ax_reg;
        mul_b        = ax_reg;
        sqrt_start   = 1'b0;
        div_start    = 1'b0;
        div_dividend = {seg_dist, 8'b0};
        div_divisor  = DVS_W'(ivl_reg);
        div_steps    = SPEED_DIV_STEPS;
        unique case (state_reg)
            ST_IDLE:
            begin
                point.ready = 1'b1;
            end
            ST_SQ_Y:
            begin
                mul_a = ay_reg;
                mul_b = ay_reg;
            end
            ST_SQRT_GO:
            begin
                sqrt_start = 1'b1;
            end
            ST_SPD_GO:
            begin
                div_start = 1'b1;
            end
            ST_MEAN_MUL:
            begin
                mul_a = COORD_W'(ivl_reg);
                mul_b = COORD_W'(segs_reg);
            end
            ST_MEAN_GO:
            begin
                div_start    = 1'b1;
                div_dividend = sum_reg;
                div_divisor  = prod_reg[DVS_W-1:0];
                div_steps    = MEAN_DIV_STEPS;
            end
            ST_SQ_X, ST_SQRT_WAIT, ST_SPD_WAIT, ST_UPDATE, ST_CHECK,
            ST_MEAN_WAIT, ST_FINISH:
            begin
                point.ready = 1'b0;
            end
            default:
            begin
                point.ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Shared multiplier with its product register.
    assign prod_next = mul_a * mul_b;
    assign radicand  = SQ_W'(sq_reg) + SQ_W'(prod_reg);

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_SQ_X || state_reg == ST_MEAN_MUL)
        begin
            prod_reg <= prod_next;
        end
        else if (state_reg == ST_SQ_Y)
        begin
            sq_reg   <= prod_reg;
            prod_reg <= prod_next;
        end
    end

    tss_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (radicand),
        .sts      (sqrt_sts),
        .root     (seg_dist)
    );

    tss_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .steps    (div_steps),
        .sts      (div_sts),
        .quotient (quot)
    );

    // Captured point word and the interval in force for it.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_reg    <= pt.pos_x;
            y_reg    <= pt.pos_y;
            last_reg <= pt.last_point;
            ax_reg   <= adx[COORD_W-1:0];
            ay_reg   <= ady[COORD_W-1:0];
            ivl_reg  <= (interval_reg == '0) ? IVL_W'(1) : interval_reg;
        end
    end

    // Segment speed and the saturating path sum.
    always_comb
    begin
        speed    = quot[SPEED_W-1:0];
        sum_wide = {1'b0, sum_reg} + (PATH_W + 1)'(seg_dist);
        sum_next = sum_wide[PATH_W] ? {PATH_W{1'b1}} : sum_wide[PATH_W-1:0];
    end

    assign out_free = !out_valid_reg || result.ready;

    // Track statistics; cleared once the result word is loaded.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            have_prev_reg <= 1'b0;
            segs_reg      <= '0;
            min_reg       <= {SPEED_W{1'b1}};
            max_reg       <= '0;
            sum_reg       <= '0;
        end
        else if (accept && !have_prev_reg)
        begin
            prev_x_reg    <= pt.pos_x;
            prev_y_reg    <= pt.pos_y;
            have_prev_reg <= 1'b1;
        end
        else if (state_reg == ST_UPDATE)
        begin
            prev_x_reg <= x_reg;
            prev_y_reg <= y_reg;
            segs_reg   <= segs_reg + 1'b1;
            sum_reg    <= sum_next;
            if (speed < min_reg)
            begin
                min_reg <= speed;
            end
            if (speed > max_reg)
            begin
                max_reg <= speed;
            end
        end
        else if (state_reg == ST_FINISH && out_free)
        begin
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            have_prev_reg <= 1'b0;
            segs_reg      <= '0;
            min_reg       <= {SPEED_W{1'b1}};
            max_reg       <= '0;
            sum_reg       <= '0;
        end
    end

    // Result word: an empty track gives zeros with the empty flag.
    always_comb
    begin
        out_word_next = '0;
        if (segs_reg == '0)
        begin
            out_word_next.track_empty = 1'b1;
        end
        else
        begin
            out_word_next.min_speed     = min_reg;
            out_word_next.max_speed     = max_reg;
            out_word_next.mean_speed    = (|quot[PATH_W-1:SPEED_W]) ? {SPEED_W{1'b1}}
                                                                    : quot[SPEED_W-1:0];
            out_word_next.path_length   = sum_reg;
            out_word_next.segment_count = segs_reg;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == ST_FINISH && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_FINISH && out_free)
        begin
            out_word_reg <= out_word_next;
        end
    end

    assign result.valid   = out_valid_reg;
    assign result.payload = out_word_reg;

    // The block only takes a point word while both arithmetic units are quiet.
    assert property (@(posedge clk) disable iff (!rst_n)
        point.ready |-> !sqrt_sts.busy && !div_sts.busy)
        else $error("point accepted while an arithmetic unit is running");

    // A divider result only arrives when the sequencer is waiting for one.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_sts.done |-> (state_reg == ST_SPD_WAIT || state_reg == ST_MEAN_WAIT))
        else $error("divider finished outside a wait state");

    // The segment count never passes its limit.
    assert property (@(posedge clk) disable iff (!rst_n)
        segs_reg <= SEG_LIMIT)
        else $error("segment count beyond limit");

    // An empty track reports no segments and no path.
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.payload.track_empty |->
            result.payload.segment_count == '0 && result.payload.path_length == '0)
        else $error("empty track with nonzero statistics");

endmodule

### hdl/tss_sqrt.sv
module tss_sqrt
    import tss_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [SQ_W-1:0]   radicand,
    output unit_sts_t         sts,
    output logic [DIST_W-1:0] root
);

    localparam int unsigned RAD_W = 2 * ROOT_STEPS;
    localparam int unsigned REM_W = DIST_W + 1;
    localparam int unsigned SH_W  = REM_W + 2;

    logic [RAD_W-1:0]      rad_reg;
    logic [REM_W-1:0]      rem_reg;
    logic [DIST_W-1:0]     root_reg;
    logic [ROOT_CNT_W-1:0] cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;

    logic [SH_W-1:0] rem_sh;
    logic [SH_W-1:0] trial;
    logic [SH_W-1:0] diff;
    logic            fits;

    // One restoring step: bring down two radicand bits and try root*4+1.
    always_comb
    begin
        rem_sh = {rem_reg, rad_reg[RAD_W-1 -: 2]};
        trial  = {1'b0, root_reg, 2'b01};
        diff   = rem_sh - trial;
        fits   = (rem_sh >= trial);
    end

    // Step counter and handshake with the sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= ROOT_CNT_W'(ROOT_STEPS - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Radicand, partial remainder and root.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= RAD_W'(radicand);
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
            rem_reg  <= fits ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
            root_reg <= {root_reg[DIST_W-2:0], fits};
        end
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign root     = root_reg;

endmodule

### hdl/tss_div.sv
module tss_div
    import tss_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [PATH_W-1:0]    dividend,
    input  logic [DVS_W-1:0]     divisor,
    input  logic [DIV_CNT_W-1:0] steps,
    output unit_sts_t            sts,
    output logic [PATH_W-1:0]    quotient
);

    logic [PATH_W-1:0]    dvd_reg;
    logic [DVS_W-1:0]     dvs_reg;
    logic [DVS_W-1:0]     rem_reg;
    logic [PATH_W-1:0]    quot_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [DVS_W:0] rem_sh;
    logic [DVS_W:0] diff;
    logic           fits;

    // One restoring step: shift in the next dividend bit and try the divisor.
    always_comb
    begin
        rem_sh = {rem_reg, dvd_reg[PATH_W-1]};
        diff   = rem_sh - {1'b0, dvs_reg};
        fits   = (rem_sh >= {1'b0, dvs_reg});
    end

    // Step counter and handshake with the sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= steps - 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Operands, remainder and quotient.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg  <= dividend;
            dvs_reg  <= divisor;
            rem_reg  <= '0;
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg  <= {dvd_reg[PATH_W-2:0], 1'b0};
            rem_reg  <= fits ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
            quot_reg <= {quot_reg[PATH_W-2:0], fits};
        end
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign quotient = quot_reg;

endmodule

### tb/trajectory_speed_statistics_top_tb.sv
module trajectory_speed_statistics_top_tb
    import tss_pkg::*;
;

    localparam int MAX_POINTS = 256;
    localparam int SEG_LIMIT = (MAX_POINTS - 1 > 255) ? 255 : MAX_POINTS - 1;
    localparam longint CYCLE_LIMIT = 1_000_000;
    localparam int SETTLE_CYCLES = 150;
    localparam int COORD_MAX = 8388607;
    localparam int COORD_MIN = -8388608;
    localparam logic [PATH_W-1:0] PATH_SAT = '1;
    localparam logic [SPEED_W-1:0] SPEED_SAT = '1;

    logic clk;
    logic rst_n;

    tss_chan_if #(.payload_t(point_word_t)) point_ch ();
    tss_chan_if #(.payload_t(ivl_word_t)) cfg_ch ();
    tss_chan_if #(.payload_t(result_word_t)) result_ch ();

    trajectory_speed_statistics_top #(
        .MAX_POINTS(MAX_POINTS)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .point(point_ch),
        .cfg(cfg_ch),
        .result(result_ch)
    );

    // Track statistics as the block should hold them.
    logic signed [COORD_W-1:0] trk_prev_x;
    logic signed [COORD_W-1:0] trk_prev_y;
    logic trk_started;
    int trk_segments;
    logic [SPEED_W-1:0] trk_min;
    logic [SPEED_W-1:0] trk_max;
    logic [PATH_W-1:0] trk_path;
    ivl_word_t cfg_interval;

    result_word_t pending_results[$];

    int tx_idle_pct;
    int rx_idle_pct;
    int rx_hold_left;
    int mismatch_count;
    int items_sent;
    longint cycle_count;

    // Clock with a period of 10.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic log_mismatch(input string what, input logic [63:0] got,
                                input logic [63:0] want);
        $display("error at cycle %0d: %s got %0d, expected %0d",
                 cycle_count, what, got, want);
        mismatch_count++;
    endtask

    function automatic void clear_track();
        trk_prev_x = '0;
        trk_prev_y = '0;
        trk_started = 1'b0;
        trk_segments = 0;
        trk_min = '1;
        trk_max = '0;
        trk_path = '0;
    endfunction

    // Truncating square root, one result bit at a time from the top.
    function automatic logic [SPEED_W-1:0] segment_root(input logic [63:0] v);
        logic [63:0] root;
        logic [63:0] trial;
        root = '0;
        for (int b = SPEED_W - 1; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (trial * trial <= v)
                root = trial;
        end
        return root[SPEED_W-1:0];
    endfunction

    // Folds one accepted point into the track and queues the summary word
    // when the point closes the track.
    function automatic void advance_track(input point_word_t pt);
        longint dx;
        longint dy;
        longint ax;
        longint ay;
        logic [63:0] ivl;
        logic [63:0] seg_len;
        logic [63:0] speed;
        logic [63:0] sum;
        logic [63:0] mean;
        result_word_t res;
        ivl = (cfg_interval == '0) ? 64'd1 : 64'(cfg_interval);
        if (!trk_started)
        begin
            trk_prev_x = pt.pos_x;
            trk_prev_y = pt.pos_y;
            trk_started = 1'b1;
        end
        else if (trk_segments < SEG_LIMIT)
        begin
            dx = longint'($signed(pt.pos_x)) - longint'($signed(trk_prev_x));
            dy = longint'($signed(pt.pos_y)) - longint'($signed(trk_prev_y));
            ax = (dx < 0) ? -dx : dx;
            ay = (dy < 0) ? -dy : dy;
            seg_len = 64'(segment_root(64'(ax * ax + ay * ay)));
            speed = seg_len / ivl;
            if (speed < 64'(trk_min))
                trk_min = speed[SPEED_W-1:0];
            if (speed > 64'(trk_max))
                trk_max = speed[SPEED_W-1:0];
            sum = 64'(trk_path) + seg_len;
            trk_path = (sum > 64'(PATH_SAT)) ? PATH_SAT : sum[PATH_W-1:0];
            trk_segments++;
            trk_prev_x = pt.pos_x;
            trk_prev_y = pt.pos_y;
        end
        if (pt.last_point)
        begin
            res = '0;
            if (trk_segments == 0)
                res.track_empty = 1'b1;
            else
            begin
                mean = 64'(trk_path) / (ivl * 64'(trk_segments));
                res.min_speed = trk_min;
                res.max_speed = trk_max;
                res.mean_speed = (mean > 64'(SPEED_SAT)) ? SPEED_SAT : mean[SPEED_W-1:0];
                res.path_length = trk_path;
                res.segment_count = trk_segments[COUNT_W-1:0];
            end
            pending_results.push_back(res);
            clear_track();
        end
    endfunction

    // Offers one point word, with random gaps before it, and waits until it is taken.
    task automatic send_point(input int x, input int y, input logic last);
        point_word_t pt;
        pt.pos_x = x[COORD_W-1:0];
        pt.pos_y = y[COORD_W-1:0];
        pt.last_point = last;
        @(negedge clk);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            point_ch.valid = 1'b0;
            @(negedge clk);
        end
        point_ch.valid = 1'b1;
        point_ch.payload = pt;
        @(posedge clk);
        while (!point_ch.ready)
            @(posedge clk);
        advance_track(pt);
        items_sent++;
    endtask

    // Stops offering points and waits for every outstanding summary word.
    task automatic drain_results();
        @(negedge clk);
        point_ch.valid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // The interval is written only once the block has gone quiet.
    task automatic write_interval(input ivl_word_t v);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.payload = v;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_interval = v;
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    function automatic int rand_coord();
        logic signed [COORD_W-1:0] c;
        c = COORD_W'($urandom);
        return int'(c);
    endfunction

    function automatic int clamp_coord(input int v);
        if (v > COORD_MAX)
            return COORD_MAX;
        if (v < COORD_MIN)
            return COORD_MIN;
        return v;
    endfunction

    // One track of random length; the way points move is chosen per track or, in one mode, per point.
    task automatic send_random_track();
        int len;
        int pick;
        int mode;
        int pmode;
        int x;
        int y;
        pick = $urandom_range(99);
        if (pick < 10)
            len = 1;
        else if (pick < 80)
            len = $urandom_range(2, 10);
        else if (pick < 95)
            len = $urandom_range(11, 40);
        else
            len = $urandom_range(41, 80);
        mode = $urandom_range(9);
        x = rand_coord();
        y = rand_coord();
        for (int i = 0; i < len; i++)
        begin
            pmode = (mode == 9) ? $urandom_range(8) : mode;
            if (pmode <= 3)
            begin
                x = rand_coord();
                y = rand_coord();
            end
            else if (pmode <= 6)
            begin
                x = clamp_coord(x + int'($urandom_range(2046)) - 1023);
                y = clamp_coord(y + int'($urandom_range(2046)) - 1023);
            end
            else if (pmode == 8)
            begin
                x = $urandom_range(1) ? COORD_MAX : COORD_MIN;
                y = $urandom_range(1) ? COORD_MAX : COORD_MIN;
            end
            send_point(x, y, i == len - 1);
        end
    endtask

    // Tracks of a single point report an empty track.
    task automatic test_one_point_tracks();
        send_point(0, 0, 1'b1);
        send_point(-1, 5, 1'b1);
        drain_results();
    endtask

    // Corner to corner, a zero-length segment and alternating bit patterns,
    // at the interval left by reset.
    task automatic test_coordinate_extremes();
        send_point(0, 0, 1'b0);
        send_point(COORD_MAX, COORD_MAX, 1'b0);
        send_point(COORD_MIN, COORD_MIN, 1'b0);
        send_point(COORD_MIN, COORD_MAX, 1'b0);
        send_point(COORD_MAX, COORD_MIN, 1'b0);
        send_point(COORD_MAX, COORD_MIN, 1'b0);
        send_point(32'h0055_5555, 32'hFFAA_AAAA, 1'b0);
        send_point(1, -1, 1'b1);
        drain_results();
    endtask

    // Interval of zero acts as one; the largest interval and an interval of three are tried too.
    task automatic test_interval_extremes();
        ivl_word_t settings[3];
        settings = '{16'd0, 16'hFFFF, 16'd3};
        foreach (settings[i])
        begin
            write_interval(settings[i]);
            send_point(0, 0, 1'b0);
            send_point(rand_coord(), rand_coord(), 1'b0);
            send_point(rand_coord(), rand_coord(), 1'b1);
        end
        drain_results();
    endtask

    // A track past the segment limit: the extra points are dropped, and the
    // dropped point marked last still closes the track with the largest path.
    task automatic test_segment_limit();
        write_interval(16'd1);
        for (int i = 0; i < SEG_LIMIT + 3; i++)
        begin
            if (i % 2 == 0)
                send_point(COORD_MIN, COORD_MIN, i == SEG_LIMIT + 2);
            else
                send_point(COORD_MAX, COORD_MAX, 1'b0);
        end
        send_point(10, 10, 1'b0);
        send_point(-300, 700, 1'b1);
        drain_results();
    endtask

    // The receiver holds off long enough for the block to stall its input,
    // then the sender pauses until all words are in before going on.
    task automatic test_output_stall();
        @(posedge clk);
        rx_hold_left = 3000;
        for (int t = 0; t < 8; t++)
        begin
            send_point(rand_coord(), rand_coord(), 1'b0);
            send_point(rand_coord(), rand_coord(), 1'b1);
        end
        drain_results();
        for (int t = 0; t < 4; t++)
        begin
            send_point(rand_coord(), rand_coord(), 1'b0);
            send_point(rand_coord(), rand_coord(), 1'b0);
            send_point(rand_coord(), rand_coord(), 1'b1);
        end
        drain_results();
    endtask

    task automatic test_random_tracks(input int n_points, input int tx_pct,
                                      input int rx_pct, input ivl_word_t ivl);
        int target;
        write_interval(ivl);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        target = items_sent + n_points;
        while (items_sent < target)
            send_random_track();
        drain_results();
    endtask

    // Result side: ready changes at the falling edge, with an optional long hold.
    always @(negedge clk)
    begin
        if (rx_hold_left > 0)
        begin
            result_ch.ready = 1'b0;
            rx_hold_left--;
        end
        else
            result_ch.ready = ($urandom_range(99) >= rx_idle_pct);
    end

    // Each summary word taken is compared with the oldest expectation.
    always @(posedge clk)
    begin
        result_word_t got;
        result_word_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            got = result_ch.payload;
            if (pending_results.size() == 0)
                log_mismatch("unexpected word, path_length", 64'(got.path_length), 64'd0);
            else
            begin
                want = pending_results.pop_front();
                if (got.min_speed !== want.min_speed)
                    log_mismatch("min_speed", 64'(got.min_speed), 64'(want.min_speed));
                if (got.max_speed !== want.max_speed)
                    log_mismatch("max_speed", 64'(got.max_speed), 64'(want.max_speed));
                if (got.mean_speed !== want.mean_speed)
                    log_mismatch("mean_speed", 64'(got.mean_speed), 64'(want.mean_speed));
                if (got.path_length !== want.path_length)
                    log_mismatch("path_length", 64'(got.path_length),
                                 64'(want.path_length));
                if (got.segment_count !== want.segment_count)
                    log_mismatch("segment_count", 64'(got.segment_count),
                                 64'(want.segment_count));
                if (got.track_empty !== want.track_empty)
                    log_mismatch("track_empty", 64'(got.track_empty),
                                 64'(want.track_empty));
            end
        end
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        point_ch.valid = 1'b0;
        point_ch.payload = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.payload = '0;
        result_ch.ready = 1'b0;
        cycle_count = 0;
        mismatch_count = 0;
        items_sent = 0;
        rx_hold_left = 0;
        tx_idle_pct = 29;
        rx_idle_pct = 56;
        cfg_interval = 16'd1;
        clear_track();

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_one_point_tracks();
        test_coordinate_extremes();
        test_interval_extremes();
        test_segment_limit();
        test_output_stall();
        test_random_tracks(500, 29, 56, ivl_word_t'($urandom_range(2, 400)));
        test_random_tracks(500, 56, 29, 16'hFFFF);
        test_random_tracks(500, 0, 0, ivl_word_t'($urandom_range(0, 20)));

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
